FILE: hdl/strip_fan_triangle_assembler_assert.svh
// Assertion macros shared by the triangle assembler modules.
`ifndef STRIP_FAN_TRIANGLE_ASSEMBLER_ASSERT_SVH
`define STRIP_FAN_TRIANGLE_ASSEMBLER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SFTA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SFTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sfta_pkg.sv
package sfta_pkg;

  localparam int unsigned BUFFER_WORDS_DEF = 32'd1048576;

  localparam logic [1:0] KIND_TRI   = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_TRUNC = 2'd2;

  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST  = 2'd2;

  localparam logic [2:0] PH_CMD = 3'd0;
  localparam logic [2:0] PH_VI  = 3'd1;
  localparam logic [2:0] PH_NI  = 3'd2;
  localparam logic [2:0] PH_S   = 3'd3;
  localparam logic [2:0] PH_T   = 3'd4;

  localparam logic [15:0] FIRST_TRI_POS = 16'd2;

  typedef struct packed {
    logic signed [15:0] vi;
    logic signed [15:0] ni;
    logic signed [15:0] s;
    logic signed [15:0] t;
  } vertex_t;

  typedef struct packed {
    logic [1:0] kind;
    vertex_t    a;
    vertex_t    b;
    vertex_t    c;
  } group_t;

endpackage

FILE: hdl/sfta_cmd_if.sv
interface sfta_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] word;
  logic [19:0]        words_left;
  logic               list_start;

  modport source (output valid, word, words_left, list_start, input ready);
  modport sink (input valid, word, words_left, list_start, output ready);
endinterface

FILE: hdl/sfta_prim_if.sv
interface sfta_prim_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] vert_index;
  logic signed [15:0] norm_index;
  logic signed [15:0] tex_s;
  logic signed [15:0] tex_t;
  logic [1:0]         corner;
  logic               last;

  modport source (output valid, kind, vert_index, norm_index, tex_s, tex_t, corner, last,
                  input ready);
  modport sink (input valid, kind, vert_index, norm_index, tex_s, tex_t, corner, last,
                output ready);
endinterface

FILE: hdl/sfta_asm.sv
`include "strip_fan_triangle_assembler_assert.svh"

module sfta_asm #(
  parameter int unsigned BUFFER_WORDS = sfta_pkg::BUFFER_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  sfta_cmd_if.sink         cmd,
  output logic             grp_push,
  output sfta_pkg::group_t grp,
  input  logic             grp_ready
);

  logic               hold_valid;
  logic [15:0]        hold_word;
  logic [19:0]        hold_left;
  logic               hold_start;

  logic [2:0]         phase;
  logic               stopped;
  logic               fan_mode;
  logic [15:0]        verts_total;
  logic [15:0]        vert_position;
  sfta_pkg::vertex_t  first_vertex;
  sfta_pkg::vertex_t  older_vertex;
  sfta_pkg::vertex_t  newer_vertex;
  logic signed [15:0] bld_vi;
  logic signed [15:0] bld_ni;
  logic signed [15:0] bld_s;

  logic               run;
  logic [2:0]         phase_eff;
  logic               is_end;
  logic               is_fan;
  logic [15:0]        count;
  logic [17:0]        need;
  logic               trunc;
  logic               emit_tri;
  logic               produces;
  logic               advance;
  logic [16:0]        pos_inc;
  sfta_pkg::vertex_t  cur;

  always_comb begin
    run       = hold_start || !stopped;
    phase_eff = hold_start ? sfta_pkg::PH_CMD : phase;
    is_end    = (hold_word == 16'd0);
    is_fan    = hold_word[15];
    count     = is_fan ? (~hold_word + 16'd1) : hold_word;
    need      = {count, 2'b00};
    trunc     = (20'(need) > hold_left) || (32'(need) > 32'(BUFFER_WORDS));
    emit_tri  = (phase_eff == sfta_pkg::PH_T) && (vert_position >= sfta_pkg::FIRST_TRI_POS);
    produces  = run && (((phase_eff == sfta_pkg::PH_CMD) && (is_end || trunc)) || emit_tri);
    advance   = hold_valid && (!produces || grp_ready);
    pos_inc   = {1'b0, vert_position} + 17'd1;
    cur       = '{vi: bld_vi, ni: bld_ni, s: bld_s, t: $signed(hold_word)};
  end

  assign cmd.ready = !hold_valid || advance;
  assign grp_push  = advance && produces;

  always_comb begin
    grp = '0;
    if (phase_eff == sfta_pkg::PH_CMD) begin
      grp.kind = is_end ? sfta_pkg::KIND_END : sfta_pkg::KIND_TRUNC;
    end else begin
      grp.kind = sfta_pkg::KIND_TRI;
      grp.c    = cur;
      if (fan_mode) begin
        grp.a = first_vertex;
        grp.b = newer_vertex;
      end else if (!vert_position[0]) begin
        grp.a = older_vertex;
        grp.b = newer_vertex;
      end else begin
        grp.a = newer_vertex;
        grp.b = older_vertex;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      hold_word  <= $unsigned(cmd.word);
      hold_left  <= cmd.words_left;
      hold_start <= cmd.list_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sfta_pkg::PH_CMD;
      stopped       <= 1'b1;
      fan_mode      <= 1'b0;
      verts_total   <= 16'd0;
      vert_position <= 16'd0;
    end else if (advance && run) begin
      case (phase_eff)
        sfta_pkg::PH_CMD: begin
          if (is_end || trunc) begin
            stopped <= 1'b1;
            phase   <= sfta_pkg::PH_CMD;
          end else begin
            stopped       <= 1'b0;
            fan_mode      <= is_fan;
            verts_total   <= count;
            vert_position <= 16'd0;
            phase         <= sfta_pkg::PH_VI;
          end
        end
        sfta_pkg::PH_VI: phase <= sfta_pkg::PH_NI;
        sfta_pkg::PH_NI: phase <= sfta_pkg::PH_S;
        sfta_pkg::PH_S:  phase <= sfta_pkg::PH_T;
        sfta_pkg::PH_T: begin
          vert_position <= pos_inc[15:0];
          phase <= (pos_inc >= {1'b0, verts_total}) ? sfta_pkg::PH_CMD : sfta_pkg::PH_VI;
        end
        default: phase <= sfta_pkg::PH_CMD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance && run) begin
      case (phase_eff)
        sfta_pkg::PH_VI: bld_vi <= $signed(hold_word);
        sfta_pkg::PH_NI: bld_ni <= $signed(hold_word);
        sfta_pkg::PH_S:  bld_s  <= $signed(hold_word);
        sfta_pkg::PH_T: begin
          if (vert_position == 16'd0) begin
            first_vertex <= cur;
          end
          older_vertex <= newer_vertex;
          newer_vertex <= cur;
        end
        default: ;
      endcase
    end
  end

  `SFTA_ASSERT_NOW(a_phase_range, 1'b1, phase <= sfta_pkg::PH_T, "phase out of range")
  `SFTA_ASSERT_NEXT(a_stall_holds, hold_valid && produces && !grp_ready, hold_valid,
                    "stalled item lost")
  `SFTA_ASSERT_NOW(a_pos_bound, !stopped && (phase != sfta_pkg::PH_CMD),
                   vert_position < verts_total, "vertex position beyond count")

endmodule

FILE: hdl/strip_fan_triangle_assembler.sv
// Triangle strip and fan assembler.
// cmd channel: one signed command-stream word per transaction, with the words
// left in the buffer after it and a list_start flag on the first word of a list.
// prim channel: one result per transaction: a triangle corner (kind 0, corner
// 0..2, last on corner 2), a list end (kind 1) or a truncated count (kind 2).
// Every fourth word of a vertex from the third vertex of a command on yields
// three transactions; end and truncation yield one.
// Throughput: one cmd transaction per cycle, limited only by the prim side
// draining each result group one transaction per cycle.
// An accepted word is decoded from the input register; its first result passes
// through the result group register before it can be taken on prim.
// A result-producing word waits in an input register while the result group
// register is busy, so cmd.ready stays high while the previous group drains
// unless another such word arrives; then cmd.ready drops until the group is gone.
// Reset: clears all control state; the block then ignores words until one with
// list_start is seen. A stalled prim side holds its current result unchanged.
`include "strip_fan_triangle_assembler_assert.svh"

module strip_fan_triangle_assembler #(
  parameter int unsigned BUFFER_WORDS = sfta_pkg::BUFFER_WORDS_DEF
) (
  input logic        clk,
  input logic        rst,
  sfta_cmd_if.sink   cmd,
  sfta_prim_if.source prim
);

  logic              grp_push;
  logic              grp_ready;
  sfta_pkg::group_t  grp_in;
  sfta_pkg::group_t  grp;
  logic              grp_valid;
  logic [1:0]        idx;
  logic [1:0]        last_idx;
  logic              at_last;
  sfta_pkg::vertex_t sel;

  sfta_asm #(
    .BUFFER_WORDS (BUFFER_WORDS)
  ) u_asm (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .grp_push  (grp_push),
    .grp       (grp_in),
    .grp_ready (grp_ready)
  );

  always_comb begin
    last_idx  = (grp.kind == sfta_pkg::KIND_TRI) ? sfta_pkg::CORNER_LAST : sfta_pkg::CORNER_FIRST;
    at_last   = (idx == last_idx);
    grp_ready = !grp_valid || (prim.ready && at_last);
    case (idx)
      2'd0:    sel = grp.a;
      2'd1:    sel = grp.b;
      default: sel = grp.c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= sfta_pkg::CORNER_FIRST;
    end else if (grp_push) begin
      grp_valid <= 1'b1;
      idx       <= sfta_pkg::CORNER_FIRST;
    end else if (prim.valid && prim.ready) begin
      if (at_last) begin
        grp_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_push) begin
      grp <= grp_in;
    end
  end

  assign prim.valid      = grp_valid;
  assign prim.kind       = grp.kind;
  assign prim.vert_index = sel.vi;
  assign prim.norm_index = sel.ni;
  assign prim.tex_s      = sel.s;
  assign prim.tex_t      = sel.t;
  assign prim.corner     = idx;
  assign prim.last       = at_last;

  `SFTA_ASSERT_NOW(a_no_overwrite, grp_push, grp_ready, "result group overwritten")
  `SFTA_ASSERT_NOW(a_corner_kind, grp_valid && (idx != sfta_pkg::CORNER_FIRST),
                   grp.kind == sfta_pkg::KIND_TRI, "extra corner on end or truncation")
  `SFTA_ASSERT_NEXT(a_drain_empty, prim.valid && prim.ready && at_last && !grp_push,
                    !prim.valid, "result repeated after last")

endmodule

FILE: dv/tb_strip_fan_triangle_assembler.sv
`timescale 1ns / 100ps

module tb_strip_fan_triangle_assembler;

  localparam int unsigned BUFFER_WORDS = sfta_pkg::BUFFER_WORDS_DEF;
  localparam int RANDOM_WORDS = 330;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [1:0] CORNER_MID = 2'd1;

  typedef struct packed {
    logic signed [15:0] word;
    logic [19:0]        words_left;
    logic               list_start;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]        kind;
    sfta_pkg::vertex_t v;
    logic [1:0]        corner;
    logic              last;
  } prim_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfta_cmd_if  cmd ();
  sfta_prim_if prim ();

  strip_fan_triangle_assembler #(.BUFFER_WORDS(BUFFER_WORDS)) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .prim(prim)
  );

  always #5 clk = ~clk;

  cmd_word_t stream_words[$];
  prim_out_t expected_prims[$];
  int        words_total = 0;
  int        words_taken = 0;
  int        fail_count = 0;
  int        idle_cycles = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  bit        quiet = 1'b0;
  bit        cmd_fire_seen = 1'b0;

  logic [2:0]        asm_phase = sfta_pkg::PH_CMD;
  bit                asm_stopped = 1'b1;
  bit                asm_fan = 1'b0;
  int                asm_total = 0;
  int                asm_pos = 0;
  sfta_pkg::vertex_t vtx_first = '0;
  sfta_pkg::vertex_t vtx_older = '0;
  sfta_pkg::vertex_t vtx_newer = '0;
  sfta_pkg::vertex_t vtx_build = '0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [19:0] rand_left(int need);
    if ($urandom_range(0, 3) == 0) return 20'($urandom_range(need, 20'hFFFFF));
    return 20'(need + $urandom_range(0, 64));
  endfunction

  task automatic queue_word(logic [15:0] w, logic [19:0] left, bit start);
    cmd_word_t cw;
    cw.word = w;
    cw.words_left = left;
    cw.list_start = start;
    stream_words = {stream_words, cw};
  endtask

  task automatic queue_vertex(logic [15:0] vi, logic [15:0] ni, logic [15:0] s,
                              logic [15:0] t);
    queue_word(vi, 20'($urandom), 1'b0);
    queue_word(ni, 20'($urandom), 1'b0);
    queue_word(s, 20'($urandom), 1'b0);
    queue_word(t, 20'($urandom), 1'b0);
  endtask

  task automatic queue_command(int n, bit fan, bit start, output bit broken);
    int          nwords;
    logic [15:0] cw;
    cw = fan ? 16'(-n) : 16'(n);
    broken = 1'b0;
    if ($urandom_range(0, 14) == 0) begin
      queue_word(cw, 20'($urandom_range(0, 4 * n - 1)), start);
      broken = 1'b1;
      return;
    end
    queue_word(cw, rand_left(4 * n), start);
    nwords = 4 * n;
    if ($urandom_range(0, 11) == 0) begin
      broken = 1'b1;
      nwords = $urandom_range(0, 4 * n - 1);
    end
    repeat (nwords) queue_word(rand_coord(), 20'($urandom), 1'b0);
  endtask

  function automatic void add_prim(logic [1:0] kind, sfta_pkg::vertex_t v,
                                   logic [1:0] corner, logic last);
    prim_out_t p;
    p.kind = kind;
    p.v = v;
    p.corner = corner;
    p.last = last;
    expected_prims = {expected_prims, p};
  endfunction

  task automatic assemble_word(cmd_word_t cw);
    int                count;
    int                avail;
    sfta_pkg::vertex_t cur;
    sfta_pkg::vertex_t a;
    sfta_pkg::vertex_t b;
    if (cw.list_start) begin
      asm_stopped = 1'b0;
      asm_phase = sfta_pkg::PH_CMD;
    end
    if (asm_stopped) return;
    avail = (cw.words_left > BUFFER_WORDS) ? int'(BUFFER_WORDS) : int'(cw.words_left);
    case (asm_phase)
      sfta_pkg::PH_CMD: begin
        if (cw.word == 16'sd0) begin
          asm_stopped = 1'b1;
          add_prim(sfta_pkg::KIND_END, '0, sfta_pkg::CORNER_FIRST, 1'b1);
        end else begin
          asm_fan = cw.word[15];
          count = asm_fan ? -int'(cw.word) : int'(cw.word);
          if (4 * count > avail) begin
            asm_stopped = 1'b1;
            add_prim(sfta_pkg::KIND_TRUNC, '0, sfta_pkg::CORNER_FIRST, 1'b1);
          end else begin
            asm_total = count;
            asm_pos = 0;
            vtx_build = '0;
            asm_phase = sfta_pkg::PH_VI;
          end
        end
      end
      sfta_pkg::PH_VI: begin
        vtx_build.vi = cw.word;
        asm_phase = sfta_pkg::PH_NI;
      end
      sfta_pkg::PH_NI: begin
        vtx_build.ni = cw.word;
        asm_phase = sfta_pkg::PH_S;
      end
      sfta_pkg::PH_S: begin
        vtx_build.s = cw.word;
        asm_phase = sfta_pkg::PH_T;
      end
      default: begin
        cur = vtx_build;
        cur.t = cw.word;
        vtx_build = '0;
        if (asm_pos >= int'(sfta_pkg::FIRST_TRI_POS)) begin
          if (asm_fan) begin
            a = vtx_first;
            b = vtx_newer;
          end else if (asm_pos % 2 == 0) begin
            a = vtx_older;
            b = vtx_newer;
          end else begin
            a = vtx_newer;
            b = vtx_older;
          end
          add_prim(sfta_pkg::KIND_TRI, a, sfta_pkg::CORNER_FIRST, 1'b0);
          add_prim(sfta_pkg::KIND_TRI, b, CORNER_MID, 1'b0);
          add_prim(sfta_pkg::KIND_TRI, cur, sfta_pkg::CORNER_LAST, 1'b1);
        end
        if (asm_pos == 0) vtx_first = cur;
        vtx_older = vtx_newer;
        vtx_newer = cur;
        asm_pos++;
        asm_phase = (asm_pos >= asm_total) ? sfta_pkg::PH_CMD : sfta_pkg::PH_VI;
      end
    endcase
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    prim_out_t want;
    cmd_word_t taken;
    if (rst) begin
      cmd_fire_seen <= 1'b0;
    end else begin
      cmd_fire_seen <= cmd.valid && cmd.ready;
      if (prim.valid && prim.ready) begin
        if (expected_prims.size() == 0) begin
          $error("unexpected result transaction: kind %0d", prim.kind);
          fail_count++;
        end else begin
          want = expected_prims.pop_front();
          check_field("kind", want.kind, prim.kind);
          check_field("vert_index", want.v.vi, prim.vert_index);
          check_field("norm_index", want.v.ni, prim.norm_index);
          check_field("tex_s", want.v.s, prim.tex_s);
          check_field("tex_t", want.v.t, prim.tex_t);
          check_field("corner", want.corner, prim.corner);
          check_field("last", want.last, prim.last);
        end
      end
      if (cmd.valid && cmd.ready) begin
        taken.word = cmd.word;
        taken.words_left = cmd.words_left;
        taken.list_start = cmd.list_start;
        assemble_word(taken);
        words_taken++;
        if ($urandom_range(0, 59) == 0) quiet = !quiet;
      end
      idle_cycles = ((cmd.valid && cmd.ready) || (prim.valid && prim.ready)) ?
                    0 : idle_cycles + 1;
    end
  end

  always @(negedge clk) begin : cmd_driver
    cmd_word_t cw;
    if (!rst && (!cmd.valid || cmd_fire_seen)) begin
      if (send_gap > 0) begin
        cmd.valid <= 1'b0;
        send_gap--;
      end else if (stream_words.size() > 0) begin
        cw = stream_words.pop_front();
        cmd.word <= cw.word;
        cmd.words_left <= cw.words_left;
        cmd.list_start <= cw.list_start;
        cmd.valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : prim_driver
    if (!rst) begin
      if (stall_left > 0) begin
        prim.ready <= 1'b0;
        stall_left--;
      end else begin
        prim.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int target;
    int n;
    int ncmd;
    bit broken;
    cmd.valid = 1'b0;
    cmd.word = '0;
    cmd.words_left = '0;
    cmd.list_start = 1'b0;
    prim.ready = 1'b0;

    // ignored while stopped, then a strip that fits exactly
    queue_word(16'd5, 20'd100, 1'b0);
    queue_word(16'd3, 20'd12, 1'b1);
    queue_vertex(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
    queue_vertex(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);
    queue_vertex(16'h0001, 16'hFFFE, 16'h5A5A, 16'hA5A5);
    // one-vertex fan, then end of list
    queue_word(16'hFFFF, 20'd4, 1'b0);
    queue_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    queue_word(16'h0000, 20'hFFFFF, 1'b0);
    // truncation, widest fan, restart mid command, largest strip truncated
    queue_word(16'd5, 20'd19, 1'b1);
    queue_word(16'h8000, 20'hFFFFF, 1'b1);
    queue_word(16'h0000, 20'h00000, 1'b1);
    queue_word(16'h7FFF, 20'd131067, 1'b1);

    target = stream_words.size() + RANDOM_WORDS;
    while (stream_words.size() < target) begin
      if ($urandom_range(0, 99) < 75) begin
        broken = 1'b0;
        ncmd = $urandom_range(1, 4);
        for (int c = 0; c < ncmd && !broken; c++) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
          queue_command(n, 1'($urandom_range(0, 1)), c == 0, broken);
        end
        if (!broken) queue_word(16'h0000, 20'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 6))
          queue_word(16'($urandom), 20'($urandom), $urandom_range(0, 2) == 0);
      end
    end
    words_total = stream_words.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (words_taken != words_total || expected_prims.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
